[rtl/iso8601_utc_timestamp_check_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the ISO 8601 UTC timestamp checker
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ISO8601_UTC_TIMESTAMP_CHECK_ASSERT_SVH
`define ISO8601_UTC_TIMESTAMP_CHECK_ASSERT_SVH

// Same-cycle implication
`define IUTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timestamp check assertion failed");

// Next-cycle implication
`define IUTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timestamp check assertion failed");

`endif

[rtl/iutc_pkg.sv]
// ---------------------------------------------------------------------------
// iutc_pkg
// Types, constants and helpers of the ISO 8601 UTC timestamp checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iutc_pkg;

  // String layout: YYYY-MM-DDTHH:MM:SSZ
  localparam int unsigned PosW = 5;
  localparam int unsigned AccW = 7;

  localparam logic [PosW-1:0] PosMax      = 5'd31;
  localparam logic [PosW-1:0] TsLen       = 5'd20;
  localparam logic [PosW-1:0] PosDash0    = 5'd4;
  localparam logic [PosW-1:0] PosDash1    = 5'd7;
  localparam logic [PosW-1:0] PosTee      = 5'd10;
  localparam logic [PosW-1:0] PosColon0   = 5'd13;
  localparam logic [PosW-1:0] PosColon1   = 5'd16;
  localparam logic [PosW-1:0] PosZulu     = 5'd19;
  localparam logic [PosW-1:0] PosCentEnd  = 5'd1;
  localparam logic [PosW-1:0] PosYearEnd  = 5'd3;
  localparam logic [PosW-1:0] PosMonthEnd = 5'd6;
  localparam logic [PosW-1:0] PosDayEnd   = 5'd9;
  localparam logic [PosW-1:0] PosHourEnd  = 5'd12;
  localparam logic [PosW-1:0] PosMinEnd   = 5'd15;

  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChTee   = 8'h54;
  localparam logic [7:0] ChZulu  = 8'h5A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Year 1000..9999 means the leading digit pair is at least 10
  localparam logic [AccW-1:0] CentMin   = 7'd10;
  localparam logic [AccW-1:0] MonthMax  = 7'd12;
  localparam logic [AccW-1:0] HourMax   = 7'd23;
  localparam logic [AccW-1:0] MinSecMax = 7'd59;

  localparam logic [AccW-1:0] MonFeb = 7'd2;
  localparam logic [AccW-1:0] MonApr = 7'd4;
  localparam logic [AccW-1:0] MonJun = 7'd6;
  localparam logic [AccW-1:0] MonSep = 7'd9;
  localparam logic [AccW-1:0] MonNov = 7'd11;

  // One character word
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } iutc_word_t;

  // Input stage to parser
  typedef struct packed {
    logic       valid;
    iutc_word_t word;
  } iutc_stage_t;

  // Days in a month, month already range checked elsewhere
  function automatic logic [AccW-1:0] month_days(input logic [AccW-1:0] mon,
                                                 input logic leap);
    logic [AccW-1:0] days;
    case (mon) inside
      MonFeb:                         days = leap ? 7'd29 : 7'd28;
      MonApr, MonJun, MonSep, MonNov: days = 7'd30;
      default:                        days = 7'd31;
    endcase
    return days;
  endfunction

  // acc * 10 + digit, as shifts and adds
  function automatic logic [AccW-1:0] acc_digit(input logic [AccW-1:0] acc,
                                                input logic [3:0] dig);
    logic [AccW-1:0] sum;
    sum = (acc << 3) + (acc << 1) + {3'b000, dig};
    return sum;
  endfunction

endpackage

`default_nettype wire

[rtl/iutc_if.sv]
// ---------------------------------------------------------------------------
// iutc_char_if / iutc_res_if
// Valid/ready channels for characters in and verdicts out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface iutc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_char;

  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface iutc_res_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, output is_valid, input ready);
  modport sink   (input valid, input is_valid, output ready);
endinterface

`default_nettype wire

[rtl/iutc_in_stage.sv]
// ---------------------------------------------------------------------------
// iutc_in_stage
// Input register: captures one character word per cycle, unless stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iutc_in_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  iutc_char_if.sink                 char_i,
  input  wire logic                 advance_i,
  output iutc_pkg::iutc_stage_t     stage_o
);
  import iutc_pkg::*;

  logic       valid_q, valid_d;
  iutc_word_t word_q, word_d;
  logic       take;

  // Free when empty or when the held word moves on this cycle
  assign char_i.ready = !valid_q || advance_i;
  assign take         = char_i.ready;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (take) begin
      valid_d = char_i.valid;
      if (char_i.valid) begin
        word_d.char_byte = char_i.char_byte;
        word_d.last_char = char_i.last_char;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.word  = word_q;

endmodule

`default_nettype wire

[rtl/iutc_parser.sv]
// ---------------------------------------------------------------------------
// iutc_parser
// Position tracking, field accumulation, final range checks, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iutc_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire iutc_pkg::iutc_stage_t stage_i,
  output logic                      advance_o,
  iutc_res_if.source                res_o
);
  import iutc_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic            err_q, err_d;
  logic [AccW-1:0] cent_q, cent_d;    // first two year digits
  logic [AccW-1:0] yrlo_q, yrlo_d;    // last two year digits
  logic [AccW-1:0] mon_q, mon_d;
  logic [AccW-1:0] day_q, day_d;
  logic [AccW-1:0] hr_q, hr_d;
  logic [AccW-1:0] min_q, min_d;
  logic [AccW-1:0] sec_q, sec_d;
  logic            res_valid_q, res_valid_d;
  logic            is_valid_q, is_valid_d;

  logic [7:0]      ch;
  logic            is_dig;
  logic [3:0]      dig;
  logic            err_now;
  logic            leap;
  logic [AccW-1:0] mdays;
  logic            fields_ok;
  logic            ok;

  assign ch     = stage_i.word.char_byte;
  assign is_dig = (ch >= ChZero) && (ch <= ChNine);
  assign dig    = ch[3:0];

  // A word leaves unless it ends a string and the result slot is blocked
  assign advance_o = stage_i.valid &&
                     (!stage_i.word.last_char || !res_valid_q || res_o.ready);

  // Leap year from the digit pairs: y%4 from the low pair, century years by the high pair
  assign leap = ((yrlo_q[1:0] == 2'b00) && (yrlo_q != '0)) ||
                ((yrlo_q == '0) && (cent_q[1:0] == 2'b00));
  assign mdays = month_days(mon_q, leap);

  assign fields_ok = (cent_q >= CentMin) &&
                     (mon_q != '0) && (mon_q <= MonthMax) &&
                     (day_q != '0) && (day_q <= mdays) &&
                     (hr_q <= HourMax) && (min_q <= MinSecMax) && (sec_q <= MinSecMax);

  // Per-character check and accumulate
  always_comb begin
    err_now = 1'b0;
    cent_d  = cent_q;
    yrlo_d  = yrlo_q;
    mon_d   = mon_q;
    day_d   = day_q;
    hr_d    = hr_q;
    min_d   = min_q;
    sec_d   = sec_q;
    if (pos_q >= TsLen) begin
      err_now = 1'b1;
    end else if (pos_q == PosDash0 || pos_q == PosDash1) begin
      err_now = (ch != ChDash);
    end else if (pos_q == PosColon0 || pos_q == PosColon1) begin
      err_now = (ch != ChColon);
    end else if (pos_q == PosTee) begin
      err_now = (ch != ChTee);
    end else if (pos_q == PosZulu) begin
      err_now = (ch != ChZulu);
    end else if (!is_dig) begin
      err_now = 1'b1;
    end else if (pos_q <= PosCentEnd) begin
      cent_d = acc_digit(cent_q, dig);
    end else if (pos_q <= PosYearEnd) begin
      yrlo_d = acc_digit(yrlo_q, dig);
    end else if (pos_q <= PosMonthEnd) begin
      mon_d = acc_digit(mon_q, dig);
    end else if (pos_q <= PosDayEnd) begin
      day_d = acc_digit(day_q, dig);
    end else if (pos_q <= PosHourEnd) begin
      hr_d = acc_digit(hr_q, dig);
    end else if (pos_q <= PosMinEnd) begin
      min_d = acc_digit(min_q, dig);
    end else begin
      sec_d = acc_digit(sec_q, dig);
    end
    err_d = err_q || err_now;
    pos_d = (pos_q != PosMax) ? pos_q + 5'd1 : pos_q;
  end

  // Verdict on the final character
  assign ok = !err_d && (pos_q == PosZulu) && fields_ok;

  // Result slot
  always_comb begin
    res_valid_d = res_valid_q;
    is_valid_d  = is_valid_q;
    if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
    if (advance_o && stage_i.word.last_char) begin
      res_valid_d = 1'b1;
      is_valid_d  = ok;
    end
  end

  // String state; cleared at the end of each string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      err_q  <= 1'b0;
      cent_q <= '0;
      yrlo_q <= '0;
      mon_q  <= '0;
      day_q  <= '0;
      hr_q   <= '0;
      min_q  <= '0;
      sec_q  <= '0;
    end else if (advance_o) begin
      if (stage_i.word.last_char) begin
        pos_q  <= '0;
        err_q  <= 1'b0;
        cent_q <= '0;
        yrlo_q <= '0;
        mon_q  <= '0;
        day_q  <= '0;
        hr_q   <= '0;
        min_q  <= '0;
        sec_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        err_q  <= err_d;
        cent_q <= cent_d;
        yrlo_q <= yrlo_d;
        mon_q  <= mon_d;
        day_q  <= day_d;
        hr_q   <= hr_d;
        min_q  <= min_d;
        sec_q  <= sec_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_valid_q <= is_valid_d;
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.is_valid = is_valid_q;

endmodule

`default_nettype wire

[rtl/iso8601_utc_timestamp_check.sv]
// ISO 8601 UTC timestamp checker.
// Channel char_i carries one byte of a string per word, with last_char set on
// the final byte. Channel res_o carries one word per string: is_valid is 1
// when the string is exactly YYYY-MM-DDTHH:MM:SSZ with year 1000..9999,
// month 1..12, a day that exists in that month (Gregorian leap years),
// hour <= 23 and minute, second <= 59.
// Throughput: one byte per cycle while no verdict is stalled. The final byte
// passes the input register, then the check logic into the result register,
// where the verdict waits until res_o takes it.
// Reset: all string state clears, both registers empty, char_i.ready high.
// Receiver stall: the verdict holds in the result register; bytes of the next
// string keep flowing until its own final byte reaches the check stage, and
// then char_i.ready drops until res_o takes the pending word.
// After each verdict the checker is ready for a new string at position zero.
// ---------------------------------------------------------------------------
// iso8601_utc_timestamp_check
// Top level: input register feeding the parser and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iso8601_utc_timestamp_check (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  iutc_char_if.sink  char_i,
  iutc_res_if.source res_o
);
  import iutc_pkg::*;

  iutc_stage_t stage;
  logic        advance;

  iutc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_i    (char_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  iutc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_o (advance),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

[rtl/iutc_checker.sv]
// ---------------------------------------------------------------------------
// iutc_checker
// Port-level assertions for the timestamp checker, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "iso8601_utc_timestamp_check_assert.svh"

module iutc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_last_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_is_valid_i
);

  // Pending verdict stays put while the receiver stalls
  `IUTC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_is_valid_i))

  // A new verdict follows an accepted final byte, through input and result registers
  `IUTC_ASSERT_SAME(a_res_cause, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i && in_last_i, 2))

  // With no pending verdict the input side never stalls
  `IUTC_ASSERT_SAME(a_in_free, clk_i, rst_ni, !out_valid_i, in_ready_i)

endmodule

bind iso8601_utc_timestamp_check iutc_checker u_iutc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (char_i.valid),
  .in_ready_i     (char_i.ready),
  .in_last_i      (char_i.last_char),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_is_valid_i (res_o.is_valid)
);

`default_nettype wire

[verif/iso8601_utc_timestamp_check_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iso8601_utc_timestamp_check_test
// Self-checking bench for the UTC timestamp checker. Strings go in one byte
// per word; a local model of the parser tracks the accepted bytes and queues
// the expected verdict of each string. Every verdict word is compared with
// the oldest queued verdict. Both channels idle at random except in the
// final back-to-back phase.
// ---------------------------------------------------------------------------

module iso8601_utc_timestamp_check_test;
  import iutc_pkg::*;

  localparam int unsigned YearLo = 1000;
  localparam int unsigned YearHi = 9999;

  logic clk_i = 1'b0;
  logic rst_ni;

  iutc_char_if char_if ();
  iutc_res_if  res_if ();

  iso8601_utc_timestamp_check u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Idle chances in percent, per side
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned err_cnt   = 0;

  // Verdicts of strings whose final byte was taken
  logic       verdict_q[$];
  // Bytes of the string being built
  logic [7:0] line_buf[$];

  // Parser model state
  logic [4:0]  scan_pos  = '0;
  logic        bad_form  = 1'b0;
  logic [13:0] year_sum  = '0;
  logic [6:0]  month_sum = '0;
  logic [6:0]  day_sum   = '0;
  logic [6:0]  hour_sum  = '0;
  logic [6:0]  min_sum   = '0;
  logic [6:0]  sec_sum   = '0;

  // Advance the parser model by one byte; queue a verdict on the final one
  function automatic void parse_byte(input logic [7:0] ch, input logic fin);
    logic [4:0] at;
    logic       digit;
    logic [3:0] dval;
    logic       leap;
    logic [6:0] mdays;
    logic       ok;
    at    = scan_pos;
    digit = (ch >= ChZero) && (ch <= ChNine);
    dval  = digit ? 4'(ch - ChZero) : 4'd0;
    if (at >= TsLen) begin
      bad_form = 1'b1;
    end else if (at == PosDash0 || at == PosDash1) begin
      if (ch != ChDash) bad_form = 1'b1;
    end else if (at == PosColon0 || at == PosColon1) begin
      if (ch != ChColon) bad_form = 1'b1;
    end else if (at == PosTee) begin
      if (ch != ChTee) bad_form = 1'b1;
    end else if (at == PosZulu) begin
      if (ch != ChZulu) bad_form = 1'b1;
    end else if (!digit) begin
      bad_form = 1'b1;
    end else if (at <= PosYearEnd) begin
      year_sum = 14'(year_sum * 10 + dval);
    end else if (at <= PosMonthEnd) begin
      month_sum = 7'(month_sum * 10 + dval);
    end else if (at <= PosDayEnd) begin
      day_sum = 7'(day_sum * 10 + dval);
    end else if (at <= PosHourEnd) begin
      hour_sum = 7'(hour_sum * 10 + dval);
    end else if (at <= PosMinEnd) begin
      min_sum = 7'(min_sum * 10 + dval);
    end else begin
      sec_sum = 7'(sec_sum * 10 + dval);
    end
    if (scan_pos != PosMax) scan_pos = scan_pos + 5'd1;

    if (fin) begin
      leap = ((year_sum % 4 == 0) && (year_sum % 100 != 0)) || (year_sum % 400 == 0);
      case (month_sum)
        MonFeb:                         mdays = leap ? 7'd29 : 7'd28;
        MonApr, MonJun, MonSep, MonNov: mdays = 7'd30;
        default:                        mdays = 7'd31;
      endcase
      ok = !bad_form && (at == PosZulu)
           && (year_sum >= YearLo) && (year_sum <= YearHi)
           && (month_sum >= 7'd1) && (month_sum <= 7'd12)
           && (day_sum >= 7'd1) && (day_sum <= mdays)
           && (hour_sum <= 7'd23) && (min_sum <= 7'd59) && (sec_sum <= 7'd59);
      verdict_q.push_back(ok);
      scan_pos  = '0;
      bad_form  = 1'b0;
      year_sum  = '0;
      month_sum = '0;
      day_sum   = '0;
      hour_sum  = '0;
      min_sum   = '0;
      sec_sum   = '0;
    end
  endfunction

  // Check verdict words first, then feed the accepted byte to the model
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (verdict_q.size() == 0) begin
          $error("is_valid: no verdict expected, actual %0b", res_if.is_valid);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (res_if.is_valid !== want) begin
            $error("is_valid: expected %0b, actual %0b", want, res_if.is_valid);
            err_cnt++;
          end
        end
      end
      if (char_if.valid && char_if.ready) parse_byte(char_if.char_byte, char_if.last_char);
    end
  end

  // Receiver: stall bursts of random length
  initial begin
    res_if.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  // One byte word, after an optional idle burst
  task automatic send_char(input logic [7:0] ch, input logic fin);
    int unsigned gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 13);
      @(negedge clk_i);
      char_if.valid     <= 1'b0;
      char_if.char_byte <= 8'($urandom);
      char_if.last_char <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    char_if.valid     <= 1'b1;
    char_if.char_byte <= ch;
    char_if.last_char <= fin;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
  endtask

  // Send the built string, final byte flagged
  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic put_digits(input int unsigned v, input int unsigned n);
    int unsigned scale;
    scale = (n == 4) ? 1000 : 10;
    repeat (n) begin
      line_buf.push_back(ChZero + 8'((v / scale) % 10));
      scale = scale / 10;
    end
  endtask

  task automatic put_timestamp(input int unsigned y, input int unsigned mo,
                               input int unsigned d, input int unsigned h,
                               input int unsigned mi, input int unsigned s);
    put_digits(y, 4);
    line_buf.push_back(ChDash);
    put_digits(mo, 2);
    line_buf.push_back(ChDash);
    put_digits(d, 2);
    line_buf.push_back(ChTee);
    put_digits(h, 2);
    line_buf.push_back(ChColon);
    put_digits(mi, 2);
    line_buf.push_back(ChColon);
    put_digits(s, 2);
    line_buf.push_back(ChZulu);
  endtask

  // Well-formed string, fields biased toward range and calendar edges
  task automatic put_random_timestamp();
    int unsigned y, mo, d, h, mi, s;
    case ($urandom_range(0, 7))
      0:       y = YearLo;
      1:       y = YearHi;
      2:       y = $urandom_range(0, YearLo - 1);
      3:       y = 400 * $urandom_range(3, 24);
      4:       y = 100 * $urandom_range(10, 99);
      5:       y = 4 * $urandom_range(250, 2499);
      default: y = $urandom_range(YearLo, YearHi);
    endcase
    case ($urandom_range(0, 9))
      0, 1:    mo = MonFeb;
      2:       mo = $urandom_range(0, 99);
      3:       mo = $urandom_range(0, 1) ? 0 : 13;
      default: mo = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 9))
      0:       d = $urandom_range(0, 99);
      1:       d = $urandom_range(0, 1) ? 0 : 32;
      2, 3, 4: d = $urandom_range(28, 31);
      default: d = $urandom_range(1, 31);
    endcase
    case ($urandom_range(0, 7))
      0:       h = $urandom_range(0, 99);
      1:       h = $urandom_range(23, 24);
      default: h = $urandom_range(0, 23);
    endcase
    case ($urandom_range(0, 7))
      0:       mi = $urandom_range(0, 99);
      1:       mi = $urandom_range(59, 60);
      default: mi = $urandom_range(0, 59);
    endcase
    case ($urandom_range(0, 7))
      0:       s = $urandom_range(0, 99);
      1:       s = $urandom_range(59, 60);
      default: s = $urandom_range(0, 59);
    endcase
    put_timestamp(y, mo, d, h, mi, s);
  endtask

  // Damaged or noise string
  task automatic put_broken_line();
    int unsigned idx;
    int unsigned keep;
    case ($urandom_range(0, 3))
      // one byte replaced: near-digit, separator, digit or anything
      0: begin
        put_random_timestamp();
        idx = $urandom_range(0, 19);
        case ($urandom_range(0, 3))
          0:       line_buf[idx] = $urandom_range(0, 1) ? 8'h2F : 8'h3A;
          1:       line_buf[idx] = 8'($urandom);
          2: begin
            case ($urandom_range(0, 3))
              0:       line_buf[idx] = ChDash;
              1:       line_buf[idx] = ChColon;
              2:       line_buf[idx] = ChTee;
              default: line_buf[idx] = ChZulu;
            endcase
          end
          default: line_buf[idx] = ChZero + 8'($urandom_range(0, 9));
        endcase
      end
      // cut short
      1: begin
        put_random_timestamp();
        keep = $urandom_range(1, 19);
        while (line_buf.size() > keep) void'(line_buf.pop_back());
      end
      // too long, up to past the position limit
      2: begin
        put_random_timestamp();
        repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom));
      end
      default: begin
        repeat ($urandom_range(1, 40)) line_buf.push_back(8'($urandom));
      end
    endcase
  endtask

  task automatic test_directed();
    gap_pct   = 20;
    stall_pct = 20;
    put_timestamp(YearHi, 12, 31, 23, 59, 59);
    send_line();
    // single-byte strings, non-digits at both byte extremes
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(ChZulu, 1'b1);
    line_buf.push_back(ChNine);
    line_buf.push_back(ChZero);
    send_line();
  endtask

  task automatic test_wellformed();
    repeat (45) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 40;
      endcase
      stall_pct = $urandom_range(0, 1) ? 0 : 30;
      put_random_timestamp();
      send_line();
    end
  endtask

  task automatic test_broken();
    gap_pct   = 15;
    stall_pct = 25;
    repeat (25) begin
      put_broken_line();
      send_line();
    end
  endtask

  // Sender holds off until every verdict is back
  task automatic test_drain_pause();
    gap_pct   = 10;
    stall_pct = 50;
    repeat (3) begin
      put_random_timestamp();
      send_line();
      @(negedge clk_i);
      char_if.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic test_back_to_back();
    gap_pct   = 0;
    stall_pct = 0;
    repeat (15) begin
      if ($urandom_range(0, 2) == 0) put_broken_line();
      else put_random_timestamp();
      send_line();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    char_if.valid     = 1'b0;
    char_if.char_byte = 8'h00;
    char_if.last_char = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_wellformed();
    test_broken();
    test_drain_pause();
    test_back_to_back();

    // drain, then allow for the two-stage latency
    @(negedge clk_i);
    char_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/iutc_pkg.sv
rtl/iutc_if.sv
rtl/iutc_in_stage.sv
rtl/iutc_parser.sv
rtl/iso8601_utc_timestamp_check.sv
rtl/iutc_checker.sv
verif/iso8601_utc_timestamp_check_test.sv
